// ===== src/gms_pkg.sv =====
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types, widths, command codes and constant tables for the sampler.
// ----------------------------------------------------------------------------
package gms_pkg;

	localparam int MAX_RETURNS = 1024;
	localparam int AW          = $clog2(MAX_RETURNS);
	localparam int CW          = $clog2(MAX_RETURNS + 1);
	localparam int SQ_W        = 37;
	localparam int SUM_W       = SQ_W + AW;
	localparam int NUM_W       = SUM_W + 12;
	localparam int L_W         = 21;
	localparam int A_W         = 42;
	localparam int MB_W        = CW + 20;
	localparam int B_W         = CW + 21;
	localparam int D_W         = ((A_W > B_W) ? A_W : B_W) + 1;
	localparam int PADDR_W     = 3;

	localparam logic [15:0] LN2_Q16   = 16'd45426;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	localparam logic [31:0] PRIOR_MEAN_RST = 32'd0;
	localparam logic [31:0] PRIOR_VAR_RST  = 32'd16777216;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_ITERATE = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	localparam logic REG_PRIOR_MEAN = 1'b0;
	localparam logic REG_PRIOR_VAR  = 1'b1;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] return_value;
		logic signed [31:0] mean_step;
		logic signed [31:0] variance_step;
		logic [31:0]        uniform_draw;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sample_mean;
		logic [31:0]        sample_variance;
		logic               accepted;
	} out_t;

	// floor square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
		logic [63:0] a;
		logic [63:0] res;
		logic [63:0] b;
		a   = a_in;
		res = 64'd0;
		for (int j = 31; j >= 0; j--) begin
			b = 64'd1 << (2 * j);
			if (a >= res + b) begin
				a   = a - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// root 2^-(2^-i) in Q0.32
	function automatic logic [31:0] exp_root(input int idx);
		logic [63:0] r;
		r = isqrt64(64'h8000_0000_0000_0000);
		for (int i = 1; i < idx; i++) begin
			r = isqrt64(r << 32);
		end
		return r[31:0];
	endfunction

	localparam logic [31:0] EXP_ROOT [16] = '{
		exp_root(1),  exp_root(2),  exp_root(3),  exp_root(4),
		exp_root(5),  exp_root(6),  exp_root(7),  exp_root(8),
		exp_root(9),  exp_root(10), exp_root(11), exp_root(12),
		exp_root(13), exp_root(14), exp_root(15), exp_root(16)
	};

endpackage

// ===== src/gms_ram.sv =====
// ----------------------------------------------------------------------------
// gms_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module gms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== src/gms_div.sv =====
// ----------------------------------------------------------------------------
// gms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gms_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gms_pkg::NUM_W-1:0]  num,
	input  logic [31:0]                den,
	output logic [gms_pkg::NUM_W-1:0]  quot,
	output logic                       done
);
	import gms_pkg::*;

	localparam int SW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [32:0]      rem_q;
	logic [31:0]      den_q;
	logic [SW-1:0]    cnt_q;
	logic             active_q;
	logic             done_q;
	logic [32:0]      trial;
	logic [33:0]      diff;

	assign trial = {rem_q[31:0], quot_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SW'(NUM_W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (active_q) begin
			if (!diff[33]) begin
				rem_q  <= diff[32:0];
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

// ===== src/gms_log2.sv =====
// ----------------------------------------------------------------------------
// gms_log2
// Base-2 logarithm in Q.16 by repeated squaring, one fraction bit per cycle.
// ----------------------------------------------------------------------------
module gms_log2 (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              value,
	output logic [gms_pkg::L_W-1:0]  log_val,
	output logic                     done
);
	import gms_pkg::*;

	logic [30:0] x_q;
	logic [4:0]  p_q;
	logic [15:0] frac_q;
	logic [3:0]  cnt_q;
	logic        active_q;
	logic        done_q;
	logic [31:0] v;
	logic [4:0]  msb;
	logic [30:0] norm;
	logic [61:0] sq;
	logic [31:0] sq_t;

	always_comb begin
		v   = (value == 32'd0) ? 32'd1 : value;
		msb = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				msb = 5'(i);
			end
		end
		if (msb == 5'd31) begin
			norm = v[31:1];
		end else begin
			norm = 31'(v << (5'd30 - msb));
		end
	end

	assign sq   = 62'(x_q) * 62'(x_q);
	assign sq_t = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'd15) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= norm;
			p_q    <= msb;
			frac_q <= '0;
		end else if (active_q) begin
			if (sq_t[31]) begin
				x_q    <= sq_t[31:1];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				x_q    <= sq_t[30:0];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
	end

	assign log_val = {p_q, frac_q};
	assign done    = done_q;

endmodule

// ===== src/gms_exp.sv =====
// ----------------------------------------------------------------------------
// gms_exp
// 2^-(k+f) in Q1.32 as a product of constant roots, one root per cycle.
// ----------------------------------------------------------------------------
module gms_exp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] frac,
	input  logic [9:0]  shift,
	output logic [32:0] result,
	output logic        done
);
	import gms_pkg::*;

	logic [32:0] res_q;
	logic [15:0] frac_q;
	logic [9:0]  shift_q;
	logic [3:0]  cnt_q;
	logic        active_q;
	logic        done_q;
	logic [64:0] prod;

	assign prod = 65'(res_q) * 65'(EXP_ROOT[cnt_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'd15) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			res_q   <= 33'h1_0000_0000;
			frac_q  <= frac;
			shift_q <= shift;
		end else if (active_q) begin
			frac_q <= {frac_q[14:0], 1'b0};
			if (frac_q[15]) begin
				res_q <= prod[64:32];
			end
		end
	end

	assign result = (shift_q >= 10'd32) ? 33'd0 : (res_q >> shift_q[4:0]);
	assign done   = done_q;

endmodule

// ===== src/gaussian_metropolis_sampler.sv =====
// ----------------------------------------------------------------------------
// gaussian_metropolis_sampler
// Metropolis sampler for the mean and variance of stored log returns.
// ----------------------------------------------------------------------------
//  Port group   | Direction | Handshake
//  cmd          | in        | taken when start is high and busy is low
//  result       | out       | valid for one cycle while done is high
//  APB config   | in/out    | write on psel & penable & pwrite, pready tied high
//
//  Load, restart and unused kinds finish in the accept cycle; busy stays low.
//  An iterate item spends most of its time in the scan of the return RAM (one
//  read a cycle, over the n stored returns) and in the bit-serial divider.
//  Reset clears the count and sets the current pair and the prior registers
//  to their reset values; the RAM holds nothing meaningful until written.
//  The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module gaussian_metropolis_sampler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  gms_pkg::in_t                     cmd,
	output logic                             done,
	output gms_pkg::out_t                    result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gms_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import gms_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SCAN  = 11'b000_0000_0010,
		ST_DIV_C = 11'b000_0000_0100,
		ST_DIV_P = 11'b000_0000_1000,
		ST_LOG_C = 11'b000_0001_0000,
		ST_LOG_P = 11'b000_0010_0000,
		ST_TERM  = 11'b000_0100_0000,
		ST_MUL   = 11'b000_1000_0000,
		ST_SUM   = 11'b001_0000_0000,
		ST_EXP   = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] prior_mean_q;
	logic [31:0]        prior_var_q;
	logic               cfg_wr;

	// current pair and store fill
	logic signed [31:0] cur_mean_q;
	logic [31:0]        cur_var_q;
	logic [CW-1:0]      count_q;

	// proposal held for the iteration
	logic signed [31:0] prop_mean_q;
	logic [31:0]        prop_var_q;
	logic [31:0]        uni_q;

	// scan
	logic [CW-1:0]      idx_q;
	logic               v_s1, v_s2, v_s3;
	logic [32:0]        mag_c_s2, mag_p_s2;
	logic [SQ_W-1:0]    sq_c_s3, sq_p_s3;
	logic [SUM_W-1:0]   sc_q, sp_q;
	logic [31:0]        rdata;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;

	// arithmetic results
	logic [NUM_W-1:0]       qc_q, qp_q;
	logic [L_W-1:0]         lc_q, lp_q;
	logic signed [A_W-1:0]  a_q;
	logic [B_W-1:0]         mag1_q;
	logic                   lneg_q;
	logic signed [B_W-1:0]  b_q;
	logic signed [D_W-1:0]  dsum_q;
	logic                   take_q;
	logic                   started_q;

	// unit ports
	logic                   div_start, div_done, log_start, log_done, exp_start, exp_done;
	logic [NUM_W-1:0]       div_num, div_quot;
	logic [31:0]            div_den, log_in;
	logic [L_W-1:0]         log_out;
	logic [32:0]            exp_out;
	logic [41:0]            y;
	logic [41:0]            y_q;

	// combinational helpers
	logic                   accept;
	logic signed [32:0]     pm_sum;
	logic signed [33:0]     pv_sum;
	logic [33:0]            pv_abs;
	logic [31:0]            pv_new;
	logic signed [32:0]     d_c, d_p;
	logic [65:0]            sq_c, sq_p;
	logic [NUM_W-1:0]       qdiff;
	logic [NUM_W-1:0]       amag;
	logic signed [L_W:0]    ldiff;
	logic [L_W-1:0]         labs;
	logic [B_W+15:0]        mag2;
	logic [D_W-1:0]         xneg;
	logic                   scan_end;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_PRIOR_VAR) ? prior_var_q : prior_mean_q;

	// proposal: saturate the mean, fold and clamp the variance
	always_comb begin
		pm_sum = 33'(cur_mean_q) + 33'(cmd.mean_step);
		pv_sum = $signed({2'b00, cur_var_q}) + 34'(cmd.variance_step);
		pv_abs = pv_sum[33] ? 34'(-pv_sum) : pv_sum;
		if (pv_abs[33:32] != 2'b00) begin
			pv_new = 32'hFFFF_FFFF;
		end else if (pv_abs[31:0] == 32'd0) begin
			pv_new = 32'd1;
		end else begin
			pv_new = pv_abs[31:0];
		end
	end

	// store access: scan reads, loads write at the fill count
	assign ram_we   = accept && (cmd.kind == KIND_LOAD) && (count_q < CW'(MAX_RETURNS));
	assign ram_addr = (state_q == ST_SCAN) ? idx_q[AW-1:0] : count_q[AW-1:0];

	gms_ram #(.WIDTH(32), .DEPTH(MAX_RETURNS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (cmd.return_value),
		.rdata (rdata)
	);

	assign d_c  = $signed({rdata[31], rdata}) - 33'(cur_mean_q);
	assign d_p  = $signed({rdata[31], rdata}) - 33'(prop_mean_q);
	assign sq_c = 66'(mag_c_s2) * 66'(mag_c_s2);
	assign sq_p = 66'(mag_p_s2) * 66'(mag_p_s2);
	assign scan_end = (idx_q == count_q) && !v_s1 && !v_s2 && !v_s3;

	// unit launches: one start pulse on entry to each waiting state
	assign div_start = !started_q && (state_q == ST_DIV_C || state_q == ST_DIV_P);
	assign log_start = !started_q && (state_q == ST_LOG_C || state_q == ST_LOG_P);
	assign exp_start = !started_q && (state_q == ST_EXP);
	assign div_num   = (state_q == ST_DIV_C) ? {sc_q, 12'd0} : {sp_q, 12'd0};
	assign div_den   = (state_q == ST_DIV_C) ? cur_var_q : prop_var_q;
	assign log_in    = (state_q == ST_LOG_C) ? cur_var_q : prop_var_q;

	gms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	gms_log2 u_log2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (log_start),
		.value   (log_in),
		.log_val (log_out),
		.done    (log_done)
	);

	gms_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.frac   (y_q[31:16]),
		.shift  (y_q[41:32]),
		.result (exp_out),
		.done   (exp_done)
	);

	// quotient term (half the difference, magnitude capped at 2^40), log term and exp input
	always_comb begin
		qdiff = (qc_q >= qp_q) ? (qc_q - qp_q) : (qp_q - qc_q);
		amag  = qdiff >> 1;
		if (amag > (NUM_W'(1) << 40)) begin
			amag = NUM_W'(1) << 40;
		end
		ldiff = $signed({1'b0, lc_q}) - $signed({1'b0, lp_q});
		labs  = ldiff[L_W] ? L_W'(-ldiff) : L_W'(ldiff);
		mag2  = (B_W + 16)'(mag1_q) * (B_W + 16)'(LN2_Q16);
		xneg  = D_W'(-dsum_q);
		y     = 42'(xneg[24:0]) * 42'(LOG2E_Q16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prior_mean_q <= PRIOR_MEAN_RST;
			prior_var_q  <= PRIOR_VAR_RST;
			cur_mean_q   <= PRIOR_MEAN_RST;
			cur_var_q    <= PRIOR_VAR_RST;
			count_q      <= '0;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			started_q    <= 1'b0;
			done         <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == REG_PRIOR_VAR) begin
					prior_var_q <= pwdata;
				end else begin
					prior_mean_q <= pwdata;
				end
			end
			if (div_start || log_start || exp_start) begin
				started_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							KIND_LOAD: begin
								if (ram_we) begin
									count_q <= count_q + 1'b1;
								end
							end
							KIND_RESTART: begin
								cur_mean_q <= prior_mean_q;
								cur_var_q  <= (prior_var_q == 32'd0) ? 32'd1 : prior_var_q;
								count_q    <= '0;
							end
							KIND_ITERATE: begin
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// issue one read a cycle; the pipe drains before leaving
					v_s1 <= (idx_q != count_q);
					v_s2 <= v_s1;
					v_s3 <= v_s2;
					if (idx_q != count_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DIV_C;
					end
				end
				ST_DIV_C: begin
					if (div_done) begin
						started_q <= 1'b0;
						state_q   <= ST_DIV_P;
					end
				end
				ST_DIV_P: begin
					if (div_done) begin
						started_q <= 1'b0;
						state_q   <= ST_LOG_C;
					end
				end
				ST_LOG_C: begin
					if (log_done) begin
						started_q <= 1'b0;
						state_q   <= ST_LOG_P;
					end
				end
				ST_LOG_P: begin
					if (log_done) begin
						started_q <= 1'b0;
						state_q   <= ST_TERM;
					end
				end
				ST_TERM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!dsum_q[D_W-1]) begin
						state_q <= ST_DONE;
					end else if (xneg > D_W'(1 << 24)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					if (exp_done) begin
						started_q <= 1'b0;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take_q) begin
						cur_mean_q <= prop_mean_q;
						cur_var_q  <= prop_var_q;
					end
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pm_sum > 33'sd2147483647) begin
				prop_mean_q <= 32'sh7FFF_FFFF;
			end else if (pm_sum < -33'sd2147483648) begin
				prop_mean_q <= 32'sh8000_0000;
			end else begin
				prop_mean_q <= pm_sum[31:0];
			end
			prop_var_q <= pv_new;
			uni_q      <= cmd.uniform_draw;
			sc_q       <= '0;
			sp_q       <= '0;
		end
		mag_c_s2 <= d_c[32] ? 33'(-d_c) : d_c;
		mag_p_s2 <= d_p[32] ? 33'(-d_p) : d_p;
		sq_c_s3  <= sq_c[SQ_W+27:28];
		sq_p_s3  <= sq_p[SQ_W+27:28];
		if (state_q == ST_SCAN && v_s3) begin
			sc_q <= sc_q + SUM_W'(sq_c_s3);
			sp_q <= sp_q + SUM_W'(sq_p_s3);
		end
		if (div_done) begin
			if (state_q == ST_DIV_C) begin
				qc_q <= div_quot;
			end else begin
				qp_q <= div_quot;
			end
		end
		if (log_done) begin
			if (state_q == ST_LOG_C) begin
				lc_q <= log_out;
			end else begin
				lp_q <= log_out;
			end
		end
		if (state_q == ST_TERM) begin
			a_q    <= (qc_q >= qp_q) ? A_W'(amag) : A_W'(-$signed({1'b0, amag}));
			mag1_q <= B_W'(count_q) * B_W'(labs);
			lneg_q <= ldiff[L_W];
		end
		if (state_q == ST_MUL) begin
			b_q <= lneg_q ? -$signed(B_W'(mag2[B_W+15:17])) : $signed(B_W'(mag2[B_W+15:17]));
		end
		if (state_q == ST_SUM) begin
			y_q    <= y;
			take_q <= !dsum_q[D_W-1];
		end else if (state_q == ST_MUL) begin
			dsum_q <= D_W'(a_q) + D_W'(lneg_q ? -$signed(B_W'(mag2[B_W+15:17]))
			                                   : $signed(B_W'(mag2[B_W+15:17])));
		end
		if (state_q == ST_EXP && exp_done) begin
			take_q <= ({1'b0, uni_q} < exp_out);
		end
	end

	assign result.sample_mean     = cur_mean_q;
	assign result.sample_variance = cur_var_q;
	assign result.accepted        = take_q;

endmodule
